// ----- hdl/slr_pkg.sv -----
// Shared constants, codes and types for the sentinel line chunk relay.
`default_nettype none

package slr_pkg;

   localparam int CHUNK_MAX    = 64;
   localparam int SENTINEL_MAX = 16;

   localparam int CHUNK_IDX_W = $clog2(CHUNK_MAX);
   localparam int CHUNK_CNT_W = $clog2(CHUNK_MAX + 1);
   localparam int SENT_IDX_W  = $clog2(SENTINEL_MAX);
   localparam int SENT_LEN_W  = $clog2(SENTINEL_MAX + 1);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int COUNTER_W   = 32;

   localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

   localparam logic CMD_PUSH  = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_SENTINEL_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SENTINEL_LOW    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SENTINEL_HIGH   = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_COMPLETE   = 2'd1,
      STATUS_SINK_ERROR = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_READ,
      ST_LOAD,
      ST_SINGLE
   } state_type;

   typedef struct packed {
      logic take_item;
      logic evaluate;
      logic read_issue;
      logic load_byte;
      logic load_single;
   } ctrl_cmd_type;

   typedef struct packed {
      logic deliver;
      logic last_byte;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- hdl/slr_if.sv -----
// Handshake channel interfaces for requests, results and register writes.
`default_nettype none

interface slr_req_if;
   import slr_pkg::*;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] data_byte;
   logic       sink_reject;

   modport source (output valid, output cmd, output data_byte, output sink_reject,
                   input ready);
   modport sink (input valid, input cmd, input data_byte, input sink_reject,
                 output ready);
endinterface

interface slr_rsp_if;
   import slr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 byte_valid;
   logic [7:0]           out_byte;
   logic                 last;
   logic [1:0]           status;
   logic [COUNTER_W-1:0] accepted_total;

   modport source (output valid, output byte_valid, output out_byte, output last,
                   output status, output accepted_total, input ready);
   modport sink (input valid, input byte_valid, input out_byte, input last,
                 input status, input accepted_total, output ready);
endinterface

interface slr_csr_if;
   import slr_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/slr_controller.sv -----
// Sequencing state machine: accepts a request, evaluates it and steps out its results.
`default_nettype none

module slr_controller
   import slr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type dp_status,
   output ctrl_cmd_type       ctrl_cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      ctrl_cmd  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl_cmd.take_item = 1'b1;
               state_in           = ST_EVAL;
            end
         end
         ST_EVAL: begin
            ctrl_cmd.evaluate = 1'b1;
            state_in          = dp_status.deliver ? ST_READ : ST_SINGLE;
         end
         ST_READ: begin
            ctrl_cmd.read_issue = 1'b1;
            state_in            = ST_LOAD;
         end
         ST_LOAD: begin
            if (dp_status.out_free) begin
               ctrl_cmd.load_byte = 1'b1;
               state_in           = dp_status.last_byte ? ST_IDLE : ST_READ;
            end
         end
         ST_SINGLE: begin
            if (dp_status.out_free) begin
               ctrl_cmd.load_single = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A taken request is always evaluated in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.take_item |=> state_ff == ST_EVAL)
      else $error("request not followed by evaluation");

   // The final byte of a run returns the controller to idle.
   assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.load_byte && dp_status.last_byte |=> state_ff == ST_IDLE)
      else $error("run did not end after its last byte");

endmodule

`default_nettype wire

// ----- hdl/slr_datapath.sv -----
// Chunk memory, sentinel window, counters, register file and result register.
`default_nettype none

module slr_datapath
   import slr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_cmd,
   input  wire logic [7:0]   req_data_byte,
   input  wire logic         req_sink_reject,
   slr_rsp_if.source         rsp,
   slr_csr_if.sink           csr,
   input  wire ctrl_cmd_type ctrl_cmd,
   output dp_status_type     dp_status
);

   // Configuration registers.
   logic [SENT_LEN_W-1:0] sent_len_ff;
   logic [CSR_DATA_W-1:0] sent_low_ff;
   logic [CSR_DATA_W-1:0] sent_high_ff;

   // Line and chunk state.
   logic [7:0]             chunk_store_ff [CHUNK_MAX];
   logic [CHUNK_CNT_W-1:0] chunk_count_ff, chunk_count_in;
   logic [7:0]             tail_window_ff [SENTINEL_MAX];
   logic [7:0]             tail_window_in [SENTINEL_MAX];
   logic [SENT_LEN_W-1:0]  tail_count_ff, tail_count_in;
   logic                   seen_ff, seen_in;
   logic [COUNTER_W-1:0]   counter_ff, counter_in;

   // Captured request and run bookkeeping.
   logic                   item_flush_ff;
   logic                   item_newline_ff;
   logic                   item_reject_ff;
   logic [CHUNK_CNT_W-1:0] run_len_ff;
   logic [CHUNK_IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [7:0]             rd_data_ff;
   status_type             status_ff, status_in;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_byte_valid_ff;
   logic [7:0]           rsp_out_byte_ff;
   logic                 rsp_last_ff;
   status_type           rsp_status_ff;
   logic [COUNTER_W-1:0] rsp_total_ff;

   logic                          push_take;
   logic                          newline_take;
   logic [SENT_LEN_W-1:0]         eff_len;
   logic [8*SENTINEL_MAX-1:0]     sentinel_vec;
   logic [7:0]                    shifted [SENTINEL_MAX];
   logic                          deliver;
   logic                          rejected;
   logic                          match;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_len_ff  <= SENT_LEN_W'(1);
         sent_low_ff  <= '0;
         sent_high_ff <= '0;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_SENTINEL_LENGTH: sent_len_ff  <= csr.data[SENT_LEN_W-1:0];
            CSR_SENTINEL_LOW:    sent_low_ff  <= csr.data;
            CSR_SENTINEL_HIGH:   sent_high_ff <= csr.data;
            default: ;
         endcase
      end
   end

   // A length of zero behaves as one, anything longer than the window as the window.
   always_comb begin
      if (sent_len_ff == '0) begin
         eff_len = SENT_LEN_W'(1);
      end else if (sent_len_ff > SENT_LEN_W'(SENTINEL_MAX)) begin
         eff_len = SENT_LEN_W'(SENTINEL_MAX);
      end else begin
         eff_len = sent_len_ff;
      end
   end

   assign sentinel_vec = {sent_high_ff, sent_low_ff};
   assign push_take    = ctrl_cmd.take_item && (req_cmd == CMD_PUSH);
   assign newline_take = (req_data_byte == NEWLINE_BYTE);

   assign deliver  = item_flush_ff ? (chunk_count_ff != '0)
                                   : (item_newline_ff
                                      || chunk_count_ff == CHUNK_CNT_W'(CHUNK_MAX));
   assign rejected = deliver && item_reject_ff;

   always_comb begin
      match = (tail_count_ff == eff_len);
      for (int i = 0; i < SENTINEL_MAX; i++) begin
         if (SENT_LEN_W'(i) < eff_len && tail_window_ff[i] != sentinel_vec[8*i +: 8]) begin
            match = 1'b0;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < SENTINEL_MAX - 1; i++) begin
         shifted[i] = tail_window_ff[i+1];
      end
      shifted[SENTINEL_MAX-1] = tail_window_ff[SENTINEL_MAX-1];
   end

   // Window: fill from the front until full, then slide left within the active length.
   always_comb begin
      tail_count_in = tail_count_ff;
      for (int i = 0; i < SENTINEL_MAX; i++) begin
         tail_window_in[i] = tail_window_ff[i];
      end
      if (push_take && !newline_take) begin
         if (tail_count_ff < eff_len) begin
            tail_window_in[tail_count_ff[SENT_IDX_W-1:0]] = req_data_byte;
            tail_count_in = tail_count_ff + SENT_LEN_W'(1);
         end else begin
            for (int i = 0; i < SENTINEL_MAX; i++) begin
               if (SENT_LEN_W'(i + 1) < eff_len) begin
                  tail_window_in[i] = shifted[i];
               end else if (SENT_LEN_W'(i + 1) == eff_len) begin
                  tail_window_in[i] = req_data_byte;
               end
            end
         end
      end
      // A newline that was passed downstream without the sentinel starts a fresh line.
      if (ctrl_cmd.evaluate && !item_flush_ff && item_newline_ff && !rejected && !seen_ff) begin
         tail_count_in = '0;
      end
   end

   always_comb begin
      chunk_count_in = chunk_count_ff;
      counter_in     = counter_ff;
      seen_in        = seen_ff;
      status_in      = status_ff;
      if (push_take) begin
         chunk_count_in = chunk_count_ff + CHUNK_CNT_W'(1);
      end
      if (ctrl_cmd.evaluate) begin
         if (deliver) begin
            chunk_count_in = '0;
            if (!item_reject_ff) begin
               counter_in = counter_ff + COUNTER_W'(chunk_count_ff);
            end
         end
         if (!item_flush_ff && !item_newline_ff && match) begin
            seen_in = 1'b1;
         end
         if (rejected) begin
            status_in = STATUS_SINK_ERROR;
         end else if (!item_flush_ff && item_newline_ff && seen_ff) begin
            status_in = STATUS_COMPLETE;
         end else begin
            status_in = STATUS_OK;
         end
      end
   end

   assign dp_status.deliver   = deliver;
   assign dp_status.last_byte = ({1'b0, rd_idx_ff} == CHUNK_CNT_W'(run_len_ff - 1'b1));
   assign dp_status.out_free  = !rsp_valid_ff || rsp.ready;

   always_comb begin
      rd_idx_in = rd_idx_ff;
      if (ctrl_cmd.evaluate) begin
         rd_idx_in = '0;
      end else if (ctrl_cmd.load_byte) begin
         rd_idx_in = rd_idx_ff + CHUNK_IDX_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl_cmd.load_byte || ctrl_cmd.load_single) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_count_ff <= '0;
         tail_count_ff  <= '0;
         seen_ff        <= 1'b0;
         counter_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         chunk_count_ff <= chunk_count_in;
         tail_count_ff  <= tail_count_in;
         seen_ff        <= seen_in;
         counter_ff     <= counter_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SENTINEL_MAX; i++) begin
         tail_window_ff[i] <= tail_window_in[i];
      end
      rd_idx_ff <= rd_idx_in;
      status_ff <= status_in;
      if (ctrl_cmd.take_item) begin
         item_flush_ff   <= (req_cmd == CMD_FLUSH);
         item_newline_ff <= newline_take;
         item_reject_ff  <= req_sink_reject;
      end
      if (ctrl_cmd.evaluate) begin
         run_len_ff <= chunk_count_ff;
      end
      if (ctrl_cmd.load_byte) begin
         rsp_byte_valid_ff <= 1'b1;
         rsp_out_byte_ff   <= rd_data_ff;
         rsp_last_ff       <= dp_status.last_byte;
         rsp_status_ff     <= status_ff;
         rsp_total_ff      <= counter_ff;
      end else if (ctrl_cmd.load_single) begin
         rsp_byte_valid_ff <= 1'b0;
         rsp_out_byte_ff   <= '0;
         rsp_last_ff       <= 1'b1;
         rsp_status_ff     <= status_ff;
         rsp_total_ff      <= counter_ff;
      end
   end

   // Chunk memory: one write port at the fill position, one registered read port.
   always_ff @(posedge clock) begin
      if (push_take) begin
         chunk_store_ff[chunk_count_ff[CHUNK_IDX_W-1:0]] <= req_data_byte;
      end
      if (ctrl_cmd.read_issue) begin
         rd_data_ff <= chunk_store_ff[rd_idx_ff];
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.byte_valid     = rsp_byte_valid_ff;
   assign rsp.out_byte       = rsp_out_byte_ff;
   assign rsp.last           = rsp_last_ff;
   assign rsp.status         = rsp_status_ff;
   assign rsp.accepted_total = rsp_total_ff;

   // Delivering a chunk always empties it.
   assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.evaluate && deliver |=> chunk_count_ff == '0)
      else $error("chunk not cleared after delivery");

   // The window fill level never exceeds the window size.
   assert property (@(posedge clock) disable iff (reset)
      tail_count_ff <= SENT_LEN_W'(SENTINEL_MAX))
      else $error("window fill level out of range");

   // A rejected chunk leaves the accepted byte total unchanged.
   assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.evaluate && rejected |=> counter_ff == $past(counter_ff))
      else $error("rejected chunk advanced the byte total");

endmodule

`default_nettype wire

// ----- hdl/sentinel_line_chunk_relay.sv -----
// Sentinel line chunk relay is one request per pushed byte or flush, one result
// per delivered byte (or a single status result when nothing is delivered). A
// request is taken only while the block is idle. A request that delivers no
// chunk ends in a single status result; one that delivers a chunk of n bytes
// reads each byte through the chunk memory's registered read port and then
// loads it into the result register, waiting while that is still full. The result
// register frees the request side, so a new request is taken while the last
// result still waits downstream. The running byte total reported on each result
// already includes the chunk of that request unless downstream rejected it.
`default_nettype none

module sentinel_line_chunk_relay
   import slr_pkg::*;
(
   input wire logic  clock,
   input wire logic  reset,
   slr_req_if.sink   req,
   slr_rsp_if.source rsp,
   slr_csr_if.sink   csr
);

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;
   logic          req_ready;

   assign req.ready = req_ready;

   slr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .ctrl_cmd  (ctrl_cmd)
   );

   slr_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req.cmd),
      .req_data_byte   (req.data_byte),
      .req_sink_reject (req.sink_reject),
      .rsp             (rsp),
      .csr             (csr),
      .ctrl_cmd        (ctrl_cmd),
      .dp_status       (dp_status)
   );

endmodule

`default_nettype wire

// ----- tb/sentinel_line_chunk_relay_tb.sv -----
// Testbench for the sentinel line chunk relay: directed and random requests checked per result.
`timescale 1ns / 100ps

module sentinel_line_chunk_relay_tb;
   import slr_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 20;

   typedef struct {
      logic                 byte_valid;
      logic [7:0]           out_byte;
      logic                 last;
      status_type           status;
      logic [COUNTER_W-1:0] accepted_total;
   } relay_result_type;

   logic clock = 1'b0;
   logic reset;

   slr_req_if req_if ();
   slr_rsp_if rsp_if ();
   slr_csr_if csr_if ();

   sentinel_line_chunk_relay DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   // Model of the relay: register copies, chunk buffer, line window and byte total.
   logic [4:0]            cfg_len  = 5'd1;
   logic [CSR_DATA_W-1:0] cfg_low  = '0;
   logic [CSR_DATA_W-1:0] cfg_high = '0;
   logic [7:0]            chunk_buf [CHUNK_MAX];
   int                    chunk_fill = 0;
   logic [7:0]            tail_buf [SENTINEL_MAX];
   int                    tail_fill = 0;
   logic                  line_hit = 1'b0;
   logic [COUNTER_W-1:0]  bytes_taken = '0;

   relay_result_type owed_results[$];
   int               fail_count    = 0;
   int               requests_sent = 0;
   int               cycle_count   = 0;
   int               hold_off_seq  = 0;
   bit               req_gaps_on   = 1'b1;
   bit               rsp_stalls_on = 1'b1;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sentinel_line_chunk_relay test failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [7:0] line_byte();
      logic [7:0] b;
      b = 8'($urandom);
      if (b == NEWLINE_BYTE) b = ~b;
      return b;
   endfunction

   function automatic int sentinel_span();
      if (cfg_len == 0) return 1;
      if (cfg_len > SENTINEL_MAX) return SENTINEL_MAX;
      return int'(cfg_len);
   endfunction

   // Works out the results of one accepted request and queues them in order.
   function automatic void advance_relay(logic cmd, logic [7:0] data, logic reject);
      int            n;
      int            span;
      bit            match;
      bit            newline;
      status_type    st;
      logic [127:0]  sentinel;
      n  = 0;
      st = STATUS_OK;
      if (cmd == CMD_FLUSH) begin
         n = chunk_fill;
         if (n > 0 && reject) st = STATUS_SINK_ERROR;
         else bytes_taken += n;
      end else if (chunk_fill >= CHUNK_MAX) begin
         st = STATUS_SINK_ERROR;
      end else begin
         chunk_buf[chunk_fill] = data;
         chunk_fill++;
         newline = (data == NEWLINE_BYTE);
         if (!newline) begin
            span = sentinel_span();
            // A window longer than a lowered length shifts in place and never matches.
            if (tail_fill < span) begin
               tail_buf[tail_fill] = data;
               tail_fill++;
            end else begin
               for (int i = 0; i < span - 1; i++) tail_buf[i] = tail_buf[i + 1];
               tail_buf[span - 1] = data;
            end
            if (tail_fill == span) begin
               match    = 1'b1;
               sentinel = {cfg_high, cfg_low};
               for (int i = 0; i < span; i++)
                  if (tail_buf[i] != sentinel[8*i +: 8]) match = 1'b0;
               if (match) line_hit = 1'b1;
            end
         end
         if (chunk_fill == CHUNK_MAX || newline) n = chunk_fill;
         if (n > 0 && reject) begin
            st = STATUS_SINK_ERROR;
         end else begin
            bytes_taken += n;
            if (newline && line_hit) begin
               st = STATUS_COMPLETE;
            end else if (newline) begin
               tail_fill = 0;
               line_hit  = 1'b0;
            end
         end
      end
      if (n == 0) begin
         owed_results.push_back('{1'b0, 8'h00, 1'b1, st, bytes_taken});
      end else begin
         for (int i = 0; i < n; i++)
            owed_results.push_back('{1'b1, chunk_buf[i], (i == n - 1), st, bytes_taken});
         chunk_fill = 0;
      end
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      relay_result_type front;
      if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (owed_results.size() == 0) begin
            $error("result with no request outstanding: out_byte 0x%0h", rsp_if.out_byte);
            fail_count++;
         end else begin
            front = owed_results.pop_front();
            check_field("byte_valid", front.byte_valid, rsp_if.byte_valid);
            check_field("out_byte", front.out_byte, rsp_if.out_byte);
            check_field("last", front.last, rsp_if.last);
            check_field("status", front.status, rsp_if.status);
            check_field("accepted_total", front.accepted_total, rsp_if.accepted_total);
         end
      end
   end

   // Result side: random stalls, plus one long hold-off when the stimulus asks for it.
   initial begin
      int stall_left;
      int hold_off_taken;
      stall_left     = 0;
      hold_off_taken = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_seq != hold_off_taken) begin
            hold_off_taken = hold_off_seq;
            stall_left     = LONG_HOLD;
         end
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            if (rsp_stalls_on) stall_left = pick_gap();
         end
      end
   end

   task automatic send_request(input logic cmd, input logic [7:0] data, input logic reject);
      int gap;
      req_if.valid       <= 1'b1;
      req_if.cmd         <= cmd;
      req_if.data_byte   <= data;
      req_if.sink_reject <= reject;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      advance_relay(cmd, data, reject);
      requests_sent++;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      case (idx)
         CSR_SENTINEL_LENGTH: cfg_len  = value[4:0];
         CSR_SENTINEL_LOW:    cfg_low  = value;
         CSR_SENTINEL_HIGH:   cfg_high = value;
         default: ;
      endcase
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_empty_flush();
      send_request(CMD_FLUSH, 8'hFF, 1'b0);
      send_request(CMD_FLUSH, 8'h00, 1'b1);
   endtask

   // A length of zero behaves as one; the line ends without a match.
   task automatic test_length_zero();
      wait_idle();
      write_register(CSR_SENTINEL_LENGTH, 64'd0);
      write_register(CSR_SENTINEL_LOW, 64'h41);
      send_request(CMD_PUSH, 8'h00, 1'b1);
      send_request(CMD_PUSH, 8'hFF, 1'b0);
      send_request(CMD_PUSH, NEWLINE_BYTE, 1'b0);
   endtask

   // The sentinel split across two lines must not match, as each newline clears the window.
   task automatic test_line_clear();
      wait_idle();
      write_register(CSR_SENTINEL_LENGTH, 64'd2);
      write_register(CSR_SENTINEL_LOW, 64'h4241);
      send_request(CMD_PUSH, 8'h41, 1'b0);
      send_request(CMD_PUSH, NEWLINE_BYTE, 1'b0);
      send_request(CMD_PUSH, 8'h42, 1'b0);
      send_request(CMD_PUSH, NEWLINE_BYTE, 1'b0);
   endtask

   task automatic test_length_lowered();
      wait_idle();
      write_register(CSR_SENTINEL_LENGTH, 64'd31);
      write_register(CSR_SENTINEL_LOW, '1);
      write_register(CSR_SENTINEL_HIGH, '1);
      repeat (5) send_request(CMD_PUSH, 8'hFF, 1'b0);
      wait_idle();
      write_register(CSR_SENTINEL_LENGTH, 64'd2);
      repeat (3) send_request(CMD_PUSH, 8'hFF, 1'b0);
      send_request(CMD_FLUSH, 8'h5A, 1'b1);
      send_request(CMD_PUSH, NEWLINE_BYTE, 1'b0);
   endtask

   // A rejected newline leaves the line open, so the sentinel completes across it.
   task automatic test_reject_keeps_line();
      wait_idle();
      write_register(CSR_SENTINEL_LOW, 64'h4241);
      write_register(CSR_SENTINEL_HIGH, 64'd0);
      send_request(CMD_PUSH, 8'h41, 1'b0);
      send_request(CMD_PUSH, NEWLINE_BYTE, 1'b1);
      send_request(CMD_PUSH, 8'h42, 1'b0);
      send_request(CMD_PUSH, NEWLINE_BYTE, 1'b0);
   endtask

   task automatic test_full_chunk();
      for (int k = 0; k < 2; k++) begin
         repeat (CHUNK_MAX - 1) send_request(CMD_PUSH, line_byte(), $urandom_range(0, 7) == 0);
         send_request(CMD_PUSH, line_byte(), k[0]);
      end
   endtask

   task automatic test_receiver_stall();
      wait_idle();
      req_gaps_on = 1'b0;
      hold_off_seq <= hold_off_seq + 1;
      repeat (11) send_request(CMD_PUSH, line_byte(), 1'b0);
      send_request(CMD_PUSH, NEWLINE_BYTE, 1'b0);
      req_gaps_on = 1'b1;
      wait_idle();
   endtask

   task automatic send_random_lines(input int item_goal);
      int           goal;
      int           line_len;
      int           at;
      int           span;
      int           r;
      logic [127:0] sentinel;
      goal = requests_sent + item_goal;
      while (requests_sent < goal) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            line_len = $urandom_range(0, 20);
            span     = sentinel_span();
            sentinel = {cfg_high, cfg_low};
            at       = -1;
            if (line_len >= span && $urandom_range(0, 1) == 1)
               at = $urandom_range(0, line_len - span);
            for (int i = 0; i < line_len; i++) begin
               if (at >= 0 && i >= at && i < at + span)
                  send_request(CMD_PUSH, sentinel[8*(i - at) +: 8], $urandom_range(0, 9) == 0);
               else
                  send_request(CMD_PUSH, line_byte(), $urandom_range(0, 9) == 0);
               if ($urandom_range(0, 19) == 0)
                  send_request(CMD_FLUSH, 8'($urandom), $urandom_range(0, 3) == 0);
            end
            send_request(CMD_PUSH, NEWLINE_BYTE, $urandom_range(0, 6) == 0);
         end else if (r < 85) begin
            send_request(CMD_FLUSH, 8'($urandom), $urandom_range(0, 2) == 0);
         end else begin
            send_request(CMD_PUSH, 8'($urandom), $urandom_range(0, 4) == 0);
         end
      end
   endtask

   task automatic test_random_phases();
      for (int phase = 0; phase < 4; phase++) begin
         wait_idle();
         // The third phase runs with no idling on either side.
         req_gaps_on   = (phase != 2);
         rsp_stalls_on = (phase != 2);
         case (phase)
            0:       write_register(CSR_SENTINEL_LENGTH, 64'd1);
            1:       write_register(CSR_SENTINEL_LENGTH, 64'(SENTINEL_MAX));
            2:       write_register(CSR_SENTINEL_LENGTH, 64'($urandom_range(0, 31)));
            default: write_register(CSR_SENTINEL_LENGTH, 64'($urandom_range(2, 6)));
         endcase
         write_register(CSR_SENTINEL_LOW, {$urandom, $urandom});
         write_register(CSR_SENTINEL_HIGH, {$urandom, $urandom});
         send_random_lines(16);
      end
      wait_idle();
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   initial begin
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.cmd         <= CMD_PUSH;
      req_if.data_byte   <= 8'h00;
      req_if.sink_reject <= 1'b0;
      csr_if.valid       <= 1'b0;
      csr_if.index       <= CSR_SENTINEL_LENGTH;
      csr_if.data        <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_empty_flush();
      test_length_zero();
      test_line_clear();
      test_length_lowered();
      test_reject_keeps_line();
      test_full_chunk();
      test_receiver_stall();
      test_random_phases();

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("sentinel_line_chunk_relay test passed");
      end else begin
         $display("sentinel_line_chunk_relay test failed");
      end
      $finish;
   end

endmodule
